[hdl/wzn_pkg.sv]
// Shared types and fixed widths for the window z-score normalizer.
package wzn_pkg;

	localparam int SAMPW = 16;
	localparam int NUMW  = 47;
	localparam int DENW  = 33;
	localparam int INVW  = 24;

	typedef struct packed {
		logic             pull;
		logic [SAMPW-1:0] sample;
		logic             last;
	} wzn_item_t;

	typedef struct packed {
		logic      valid;
		wzn_item_t item;
	} wzn_queue_out_t;

endpackage

[hdl/wzn_front.sv]
// Input side: accepts items and holds them in a two-entry queue for the engine.
module wzn_front
	import wzn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // sample[15:0]
	input  logic             s_tlast,
	input  logic             s_tuser,   // op
	output wzn_queue_out_t   head,
	input  logic             pop
);

	wzn_item_t  ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;
	logic       push_en;
	logic       pop_en;

	assign s_tready = (count_q != 2'd2);
	assign push_en  = s_tvalid && s_tready;
	assign pop_en   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			ent_q[wr_ptr_q].pull   <= s_tuser;
			ent_q[wr_ptr_q].sample <= s_tdata;
			ent_q[wr_ptr_q].last   <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_en) wr_ptr_q <= ~wr_ptr_q;
			if (pop_en) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push_en} - {1'b0, pop_en};
		end
	end

endmodule

[hdl/wzn_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module wzn_div
	import wzn_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            done,
	output logic [NUMW-1:0] quot
);

	logic [DENW-1:0]         rem_q;
	logic [DENW-1:0]         den_q;
	logic [NUMW-1:0]         quo_q;
	logic [$clog2(NUMW)-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [DENW:0]           trial;
	logic                    fits;

	assign trial = {rem_q, quo_q[NUMW-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quot  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DENW'(trial - {1'b0, den_q}) : trial[DENW-1:0];
			quo_q <= {quo_q[NUMW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(NUMW))'(NUMW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hdl/wzn_back.sv]
// Engine: sample store, window statistics, square root and normalized output.
module wzn_back
	import wzn_pkg::*;
#(
	parameter int WINDOW = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  wzn_queue_out_t head,
	output logic           pop,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [15:0]    m_tdata,
	output logic           m_tlast,
	output logic           m_tuser
);

	localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW   = $clog2(WINDOW + 1);
	localparam int SUMW = SAMPW + CW;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MDIV = 9'b000000010,
		ST_VPAS = 9'b000000100,
		ST_VDIV = 9'b000001000,
		ST_RDIV = 9'b000010000,
		ST_ROOT = 9'b000100000,
		ST_PRD  = 9'b001000000,
		ST_PMUL = 9'b010000000,
		ST_POUT = 9'b100000000
	} wzn_state_t;

	wzn_state_t            state_q;
	logic [SAMPW-1:0]      mem [WINDOW];
	logic [SAMPW-1:0]      rd_data_q;
	logic [AW-1:0]         rd_addr;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         ridx_q;
	logic [CW-1:0]         vcnt_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [SAMPW-1:0] mean_q;
	logic [INVW-1:0]       inv_q;
	logic                  ready_q;
	logic                  v1_q;
	logic                  v2_s2;
	logic [DENW-1:0]       sq_s2;
	logic [NUMW-1:0]       sumsq_q;
	logic [DENW-1:0]       var_q;
	logic [NUMW-1:0]       root_v_q;
	logic [NUMW:0]         root_r_q;
	logic [NUMW-1:0]       root_b_q;
	logic signed [41:0]    prod_q;
	logic                  div_go_q;
	logic [NUMW-1:0]       div_num;
	logic [DENW-1:0]       div_den;
	logic                  div_done;
	logic [NUMW-1:0]       div_quot;
	logic                  out_free;
	logic                  out_we;
	logic [15:0]           out_data;
	logic                  out_last;
	logic                  out_empty;
	logic                  is_push;
	logic                  is_pull;
	logic [CW-1:0]         fill_base;
	logic signed [SUMW-1:0] sum_base;
	logic                  store_en;
	logic signed [16:0]    diff;
	logic [NUMW:0]         root_t;
	logic signed [42:0]    z_full;
	logic signed [29:0]    z_sh;
	logic [15:0]           z_sat;
	logic                  fin;

	assign out_free = !m_tvalid || m_tready;
	assign is_push  = (state_q == ST_IDLE) && head.valid && !head.item.pull;
	assign is_pull  = (state_q == ST_IDLE) && head.valid && head.item.pull;
	assign pop      = is_push || (is_pull && (ready_q || out_free));

	// A push onto a finished window starts a new one.
	assign fill_base = ready_q ? '0 : fill_q;
	assign sum_base  = ready_q ? '0 : sum_q;
	assign store_en  = is_push && (fill_base < CW'(WINDOW));

	assign rd_addr = (state_q == ST_VPAS) ? vcnt_q[AW-1:0] : ridx_q[AW-1:0];
	assign diff    = {rd_data_q[SAMPW-1], rd_data_q} - {mean_q[SAMPW-1], mean_q};

	always_comb begin
		div_num = '0;
		div_den = '0;
		case (state_q)
			ST_MDIV: begin
				// Offset by 32768 per sample keeps the rounded mean division unsigned.
				div_num = NUMW'((NUMW'(sum_q) + (NUMW'(fill_q) << 15)) << 1) + NUMW'(fill_q);
				div_den = DENW'({fill_q, 1'b0});
			end
			ST_VDIV: begin
				div_num = sumsq_q;
				div_den = DENW'(fill_q);
			end
			ST_RDIV: begin
				div_num = NUMW'(1) << 46;
				div_den = var_q;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	wzn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign root_t = root_r_q + {1'b0, root_b_q};

	assign z_full = 43'(prod_q) + 43'sd4096;
	assign z_sh   = 30'(z_full >>> 13);
	assign z_sat  = (z_sh > 30'sd32767) ? 16'h7fff :
	                (z_sh < -30'sd32768) ? 16'h8000 : z_sh[15:0];
	assign fin    = ((ridx_q + 1'b1) >= fill_q);

	always_comb begin
		out_we    = 1'b0;
		out_data  = '0;
		out_last  = 1'b0;
		out_empty = 1'b0;
		if (is_pull && !ready_q && out_free) begin
			out_we    = 1'b1;
			out_empty = 1'b1;
		end else if (state_q == ST_POUT && out_free) begin
			out_we   = 1'b1;
			out_data = z_sat;
			out_last = fin;
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) mem[fill_base[AW-1:0]] <= head.item.sample;
		rd_data_q <= mem[rd_addr];
		sq_s2     <= DENW'(diff * diff);
		prod_q    <= 42'(diff * $signed({1'b0, inv_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			ridx_q   <= '0;
			vcnt_q   <= '0;
			sum_q    <= '0;
			mean_q   <= '0;
			inv_q    <= '0;
			ready_q  <= 1'b0;
			v1_q     <= 1'b0;
			v2_s2    <= 1'b0;
			sumsq_q  <= '0;
			var_q    <= '0;
			root_v_q <= '0;
			root_r_q <= '0;
			root_b_q <= '0;
			div_go_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (out_we) begin
				m_tvalid <= 1'b1;
				m_tdata  <= out_data;
				m_tlast  <= out_last;
				m_tuser  <= out_empty;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_push) begin
						ready_q <= 1'b0;
						ridx_q  <= '0;
						fill_q  <= store_en ? fill_base + 1'b1 : fill_base;
						sum_q   <= store_en ? sum_base + SUMW'(signed'(head.item.sample))
						                    : sum_base;
						if (head.item.last) begin
							state_q  <= ST_MDIV;
							div_go_q <= 1'b1;
						end
					end else if (is_pull && ready_q) begin
						state_q <= ST_PRD;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						mean_q  <= signed'(div_quot[15:0] ^ 16'h8000);
						vcnt_q  <= '0;
						sumsq_q <= '0;
						state_q <= ST_VPAS;
					end
				end
				ST_VPAS: begin
					v1_q  <= (vcnt_q < fill_q);
					v2_s2 <= v1_q;
					if (vcnt_q < fill_q) vcnt_q <= vcnt_q + 1'b1;
					if (v2_s2) sumsq_q <= sumsq_q + NUMW'(sq_s2);
					if (vcnt_q == fill_q && !v1_q && !v2_s2) begin
						state_q  <= ST_VDIV;
						div_go_q <= 1'b1;
					end
				end
				ST_VDIV: begin
					if (div_done) begin
						var_q    <= (div_quot == '0) ? DENW'(1) : div_quot[DENW-1:0];
						state_q  <= ST_RDIV;
						div_go_q <= 1'b1;
					end
				end
				ST_RDIV: begin
					if (div_done) begin
						root_v_q <= div_quot;
						root_r_q <= '0;
						root_b_q <= NUMW'(1) << 46;
						state_q  <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if ({1'b0, root_v_q} >= root_t) begin
						root_v_q <= NUMW'({1'b0, root_v_q} - root_t);
						root_r_q <= (root_r_q >> 1) + {1'b0, root_b_q};
					end else begin
						root_r_q <= root_r_q >> 1;
					end
					root_b_q <= root_b_q >> 2;
					if (root_b_q[0]) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
						ridx_q  <= '0;
					end
				end
				ST_PRD: state_q <= ST_PMUL;
				ST_PMUL: state_q <= ST_POUT;
				ST_POUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (fin) begin
							ready_q <= 1'b0;
							fill_q  <= '0;
							sum_q   <= '0;
							ridx_q  <= '0;
						end else begin
							ridx_q <= ridx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_ROOT && root_b_q[0]) inv_q <= INVW'(
				({1'b0, root_v_q} >= root_t) ? (root_r_q >> 1) + {1'b0, root_b_q}
				                             : (root_r_q >> 1));
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(WINDOW))
		else $error("fill count above window size");

	a_ridx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> (ridx_q < fill_q))
		else $error("read index beyond held samples");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
		else $error("pending result overwritten");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> (state_q == ST_IDLE))
		else $error("window marked ready outside idle");

endmodule

[hdl/window_zscore_normalizer_core.sv]
// Top level of the window z-score normalizer.
// Push items (tuser 0) load signed Q1.15 samples, tlast closes the window, and
// pull items (tuser 1) return (x - mean) / stddev as saturating Q6.10, with tlast
// on the final one and tuser set when no window is ready. A pull passes through
// store read, subtract and multiply, and rounding and output. Closing a window
// of n samples takes three 47-step divisions through the shared divider, one
// pass over the sample store that reads one entry a cycle, and 24 square-root
// steps. A two-entry queue takes items while the engine is busy.
module window_zscore_normalizer_core
	import wzn_pkg::*;
#(
	parameter int WINDOW = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample[15:0]
	input  logic        s_tlast,   // last
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // zscore[15:0]
	output logic        m_tlast,   // final_res
	output logic        m_tuser    // empty_res
);

	wzn_queue_out_t head;
	logic           pop;

	wzn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.head     (head),
		.pop      (pop)
	);

	wzn_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
